// ===== sv/lsa_pkg.sv =====
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared types and constants for the lease slot allocator: slot geometry,
// operation and register codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package lsa_pkg;

    // Slot table geometry
    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Field widths
    localparam int TIME_W  = 64;
    localparam int LEASE_W = 32;
    localparam int MASK_W  = 8;
    localparam int SRC_W   = 2;
    localparam int ARG_W   = 4;
    localparam int CFG_W   = 32;

    // Source kinds
    localparam logic [SRC_W-1:0] SRC_NONE      = 2'd0;
    localparam logic [SRC_W-1:0] SRC_BLUETOOTH = 2'd3;

    // No slot granted
    localparam logic signed [ARG_W-1:0] NO_SLOT = -4'sd1;

    // Register reset values
    localparam logic [LEASE_W-1:0] LEASE_RESET = 32'd1000000;
    localparam logic [MASK_W-1:0]  MASK_RESET  = 8'd0;

    // Operation codes
    typedef enum logic [1:0] {
        OP_ALLOC         = 2'd0,
        OP_RELEASE       = 2'd1,
        OP_RELEASE_MATCH = 2'd2,
        OP_QUERY         = 2'd3
    } t_op;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_LEASE_TIMEOUT = 1'b0,
        CFG_RESERVED_MASK = 1'b1
    } t_cfg_idx;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;     // latch a new request
        logic              try_en;   // try to claim slot idx
        logic              rel_en;   // carry out a release on slot idx
        logic              cnt_en;   // accumulate liveness of slot idx
        logic              out_load; // capture the result
        logic [SLOT_W-1:0] idx;      // slot under work
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic              pref;      // bluetooth source with a valid preferred slot
        logic              arg_valid; // slot argument names a slot
        logic [SLOT_W-1:0] arg_idx;
        logic              claim;     // slot idx can be claimed now
    } t_dp_sts;

endpackage

// ===== sv/lease_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// lease_slot_allocator
// Session slot table with first-free allocation and lease timeout.
// ----------------------------------------------------------------------------
// One request is worked at a time. An allocate runs a preferred try, an
// in-order scan over the slots unless the preferred slot was claimed, then
// a liveness sweep; a release runs the release and then the sweep, and a
// query only the sweep. The next request can be taken in the cycle after the
// result is loaded. Both scans step one slot per cycle through a single shared
// 64-bit lease compare unit. The result sits in an output register, so a new
// request is taken once the previous one is finished even if its result has
// not yet been collected. Configuration writes land at once and must only be
// made while the block is idle.
module lease_slot_allocator
    import lsa_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    // request channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_operation,
    input  logic [TIME_W-1:0]       i_now_time,
    input  logic [SRC_W-1:0]        i_source_kind,
    input  logic signed [ARG_W-1:0] i_slot_arg,
    // result channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [ARG_W-1:0] o_granted_slot,
    output logic                    o_op_ok,
    output logic [3:0]              o_live_count,
    output logic                    o_source_live
);

    t_dp_cmd s_cmd;
    t_dp_sts s_sts;

    lsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_op    (t_op'(i_operation)),
        .i_sts   (s_sts),
        .o_cmd   (s_cmd)
    );

    lsa_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_operation),
        .i_now_time     (i_now_time),
        .i_source_kind  (i_source_kind),
        .i_slot_arg     (i_slot_arg),
        .i_cmd          (s_cmd),
        .o_sts          (s_sts),
        .o_granted_slot (o_granted_slot),
        .o_op_ok        (o_op_ok),
        .o_live_count   (o_live_count),
        .o_source_live  (o_source_live)
    );

endmodule

// ===== sv/lsa_datapath.sv =====
// ----------------------------------------------------------------------------
// lsa_datapath
// Slot table, configuration registers, request latch, one shared lease
// compare unit for claim and liveness checks, and the result register.
// ----------------------------------------------------------------------------
module lsa_datapath
    import lsa_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_data,
    // request payload
    input  logic [1:0]                i_operation,
    input  logic [TIME_W-1:0]         i_now_time,
    input  logic [SRC_W-1:0]          i_source_kind,
    input  logic signed [ARG_W-1:0]   i_slot_arg,
    // control
    input  t_dp_cmd                   i_cmd,
    output t_dp_sts                   o_sts,
    // result
    output logic signed [ARG_W-1:0]   o_granted_slot,
    output logic                      o_op_ok,
    output logic [3:0]                o_live_count,
    output logic                      o_source_live
);

    // Configuration
    logic [LEASE_W-1:0] r_lease;
    logic [MASK_W-1:0]  r_mask;

    // Slot table
    logic               r_act  [SLOTS];
    logic [SRC_W-1:0]   r_src  [SLOTS];
    logic [TIME_W-1:0]  r_last [SLOTS];

    // Latched request
    t_op                r_op;
    logic [TIME_W-1:0]  r_now;
    logic [SRC_W-1:0]   r_src_in;
    logic [ARG_W-1:0]   r_arg;

    // Progress of the request
    logic               r_found;
    logic [SLOT_W-1:0]  r_grant_idx;
    logic               r_ok;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_src_live;

    // Result register
    logic signed [ARG_W-1:0] r_out_grant;
    logic               r_out_ok;
    logic [3:0]         r_out_cnt;
    logic               r_out_src_live;

    // Selected slot and lease compare
    logic               s_act;
    logic [SRC_W-1:0]   s_src;
    logic [TIME_W-1:0]  s_last;
    logic [TIME_W:0]    s_diff;
    logic               s_future;
    logic               s_zero;
    logic               s_age_over;
    logic               s_reserved;
    logic               s_lease_over;
    logic               s_repair;
    logic               s_claim;
    logic               s_live;
    logic               s_rel_hit;
    logic               s_arg_valid;

    always_comb begin
        s_act        = r_act[i_cmd.idx];
        s_src        = r_src[i_cmd.idx];
        s_last       = r_last[i_cmd.idx];
        s_diff       = {1'b0, r_now} - {1'b0, s_last};
        s_future     = s_diff[TIME_W];
        s_zero       = (s_last == '0);
        s_age_over   = (|s_diff[TIME_W-1:LEASE_W]) || (s_diff[LEASE_W-1:0] > r_lease);
        s_reserved   = (r_src_in != SRC_BLUETOOTH) && r_mask[3'(i_cmd.idx)];
        s_lease_over = !s_zero && !s_future && s_age_over;
        s_repair     = s_act && (s_zero || s_future);
        s_claim      = !s_reserved && (!s_act || s_lease_over);
        s_live       = s_act && !s_zero && (s_future || !s_age_over);
        s_arg_valid  = !r_arg[ARG_W-1] && ({1'b0, r_arg[ARG_W-2:0]} < ARG_W'(SLOTS));
        s_rel_hit    = s_arg_valid && ((r_op == OP_RELEASE) || (s_src == r_src_in));
    end

    assign o_sts.arg_valid = s_arg_valid;
    assign o_sts.pref      = s_arg_valid && (r_src_in == SRC_BLUETOOTH);
    assign o_sts.arg_idx   = r_arg[SLOT_W-1:0];
    assign o_sts.claim     = s_claim;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lease <= LEASE_RESET;
            r_mask  <= MASK_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LEASE_TIMEOUT: r_lease <= i_cfg_data[LEASE_W-1:0];
                CFG_RESERVED_MASK: r_mask  <= i_cfg_data[MASK_W-1:0];
            endcase
        end
    end

    // Slot table updates: claim, timestamp repair, release
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_act[i]  <= 1'b0;
                r_src[i]  <= SRC_NONE;
                r_last[i] <= '0;
            end
        end else if (i_cmd.try_en && s_claim) begin
            r_act[i_cmd.idx]  <= 1'b1;
            r_src[i_cmd.idx]  <= r_src_in;
            r_last[i_cmd.idx] <= r_now;
        end else if (i_cmd.try_en && !s_reserved && s_repair) begin
            r_last[i_cmd.idx] <= r_now;
        end else if (i_cmd.rel_en && s_rel_hit) begin
            r_act[i_cmd.idx]  <= 1'b0;
            r_src[i_cmd.idx]  <= SRC_NONE;
            r_last[i_cmd.idx] <= '0;
        end
    end

    // Latch the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_op'(i_operation);
            r_now    <= i_now_time;
            r_src_in <= i_source_kind;
            r_arg    <= i_slot_arg;
        end
    end

    // Track grant, status and live count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found    <= 1'b0;
            r_ok       <= 1'b0;
            r_cnt      <= '0;
            r_src_live <= 1'b0;
        end else if (i_cmd.load) begin
            r_found    <= 1'b0;
            r_ok       <= 1'b0;
            r_cnt      <= '0;
            r_src_live <= 1'b0;
        end else begin
            if (i_cmd.try_en && s_claim) begin
                r_found <= 1'b1;
                r_ok    <= 1'b1;
            end
            if (i_cmd.rel_en && s_rel_hit) begin
                r_ok <= 1'b1;
            end
            if (i_cmd.cnt_en) begin
                r_cnt      <= r_cnt + CNT_W'(s_live);
                r_src_live <= r_src_live || (s_live && (s_src == r_src_in));
            end
        end
    end

    // Remember which slot was claimed
    always_ff @(posedge i_clk) begin
        if (i_cmd.try_en && s_claim) begin
            r_grant_idx <= i_cmd.idx;
        end
    end

    // Capture the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_grant    <= r_found ? $signed(ARG_W'(r_grant_idx)) : NO_SLOT;
            r_out_ok       <= r_ok;
            r_out_cnt      <= 4'(r_cnt);
            r_out_src_live <= r_src_live;
        end
    end

    assign o_granted_slot = r_out_grant;
    assign o_op_ok        = r_out_ok;
    assign o_live_count   = r_out_cnt;
    assign o_source_live  = r_out_src_live;

endmodule

// ===== sv/lsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsa_ctrl
// Sequencer for one request: preferred try, in-order slot scan, release,
// liveness sweep over all slots, and the result handshake.
// ----------------------------------------------------------------------------
module lsa_ctrl
    import lsa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_op     i_op,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREF,
        S_SCAN,
        S_REL,
        S_CNT,
        S_OUT
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [SLOT_W-1:0] r_idx;
    logic [SLOT_W-1:0] n_idx;
    logic              r_out_valid;
    logic              n_out_valid;

    logic s_accept;
    logic s_last;
    logic s_skip;
    logic s_out_free;

    always_comb begin
        s_accept   = (r_state == S_IDLE) && i_valid;
        s_last     = (r_idx == SLOT_W'(SLOTS - 1));
        s_skip     = i_sts.arg_valid && (r_idx == i_sts.arg_idx);
        s_out_free = !(r_out_valid && i_stall);
    end

    // Commands to the datapath
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = s_accept;
        o_cmd.idx      = r_idx;
        unique case (r_state)
            S_IDLE: ;
            S_PREF: begin
                o_cmd.idx    = i_sts.arg_idx;
                o_cmd.try_en = i_sts.pref;
            end
            S_SCAN: o_cmd.try_en = !s_skip;
            S_REL: begin
                o_cmd.idx    = i_sts.arg_idx;
                o_cmd.rel_en = 1'b1;
            end
            S_CNT:  o_cmd.cnt_en = 1'b1;
            S_OUT:  o_cmd.out_load = s_out_free;
        endcase
    end

    // Next state
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_stall;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                // Route a fresh request by its operation code
                if (i_valid) begin
                    unique case (i_op)
                        OP_ALLOC:         n_state = S_PREF;
                        OP_RELEASE,
                        OP_RELEASE_MATCH: n_state = S_REL;
                        OP_QUERY:         n_state = S_CNT;
                    endcase
                end
            end
            S_PREF: begin
                n_idx   = '0;
                n_state = (i_sts.pref && i_sts.claim) ? S_CNT : S_SCAN;
            end
            S_SCAN: begin
                if ((!s_skip && i_sts.claim) || s_last) begin
                    n_idx   = '0;
                    n_state = S_CNT;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_REL: begin
                n_idx   = '0;
                n_state = S_CNT;
            end
            S_CNT: begin
                if (s_last) begin
                    n_idx   = '0;
                    n_state = S_OUT;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_OUT: begin
                if (s_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule
